@@ rtl/windowed_mean_variance_core_macros.svh @@
// ----------------------------------------------------------------------------
// Windowed mean/variance core: assertion macros
// Concurrent check wrappers, removed when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_MEAN_VARIANCE_CORE_MACROS_SVH
`define WINDOWED_MEAN_VARIANCE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WMV_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define WMV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define WMV_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define WMV_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/wmv_pkg.sv @@
// ----------------------------------------------------------------------------
// wmv_pkg
// Shared widths, limits, sequencer states and control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package wmv_pkg;

   // port widths
   localparam int LEVEL_W  = 10;
   localparam int MEAN_W   = 10;
   localparam int SPREAD_W = 18;
   localparam int DEV_W    = 10;

   // result limits
   localparam int unsigned MEAN_MAX   = 1023;
   localparam int unsigned SPREAD_MAX = 262143;

   // root of an 18-bit value has 9 bits
   localparam int ROOT_BITS = SPREAD_W / 2;
   // compare-subtract unit width: covers the root trial remainder
   localparam int CSU_W = ROOT_BITS + 3;

   // parameter defaults
   localparam int WINDOW_DEF     = 7;
   localparam int LEVEL_BITS_DEF = 10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAN,
      ST_SQUARE,
      ST_VAR,
      ST_ROOT_LOAD,
      ST_ROOT,
      ST_FINISH
   } wmv_state_type;

   typedef struct packed {
      logic accept;     // input transfer, ring update
      logic mean_calc;  // capture total / WINDOW as mean, clear accumulator
      logic sq_mul;     // square current ring head, rotate ring
      logic sq_acc;     // add registered square into accumulator
      logic var_calc;   // capture square sum / WINDOW
      logic root_load;  // capture spread, start root
      logic root_step;  // one root digit step
      logic finish;     // load result register
   } wmv_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/windowed_mean_variance_core.sv @@
// ----------------------------------------------------------------------------
// windowed_mean_variance_core
// Mean, variance and root of variance over a sliding window of level values.
// ----------------------------------------------------------------------------
//  channel | ports                                  | dir | handshake
//  --------+----------------------------------------+-----+-----------------
//  request | req_level                              | in  | req_valid/ready
//  result  | rsp_mean, rsp_spread, rsp_deviation    | out | rsp_valid/ready
//
//  Per item the sequencer steps through the transfer, the mean, the square
//  sweep over the window, the variance, the root load, 9 root digit steps
//  and the result load, and takes the next level only after that load. Both
//  divides by WINDOW are reciprocal multiplications.
//  Reset clears the window, total and held level; no clearing pass.
//  A finished result waits in the output register; the next item is taken
//  meanwhile and only the final load stalls on a full output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "windowed_mean_variance_core_macros.svh"

module windowed_mean_variance_core #(
   parameter int WINDOW     = wmv_pkg::WINDOW_DEF,
   parameter int LEVEL_BITS = wmv_pkg::LEVEL_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [wmv_pkg::LEVEL_W-1:0]   req_level,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [wmv_pkg::MEAN_W-1:0]    rsp_mean,
   output logic      [wmv_pkg::SPREAD_W-1:0]  rsp_spread,
   output logic      [wmv_pkg::DEV_W-1:0]     rsp_deviation
);
   import wmv_pkg::*;

   localparam int TOTAL_BITS  = LEVEL_BITS + $clog2(WINDOW);
   localparam int SQ_BITS     = 2 * LEVEL_BITS + $clog2(WINDOW);
   localparam int SQR_W       = 2 * LEVEL_BITS;
   localparam int WIN_BITS    = $clog2(WINDOW);
   localparam int LVL_EXT_W   = (LEVEL_BITS > LEVEL_W) ? LEVEL_BITS : LEVEL_W;
   localparam int MEAN_EXT_W  = (LEVEL_BITS > MEAN_W) ? LEVEL_BITS : MEAN_W;
   localparam int VAR_EXT_W   = (SQR_W > SPREAD_W) ? SQR_W : SPREAD_W;

   // x / WINDOW as (x * ceil(2^s / WINDOW)) >> s, exact for every x of the
   // given width when s is that width plus clog2(WINDOW)
   localparam int MEAN_SHIFT  = TOTAL_BITS + WIN_BITS;
   localparam int MEAN_PROD_W = 2 * TOTAL_BITS + 1;
   localparam longint unsigned MEAN_RCP =
      ((64'd1 << MEAN_SHIFT) + 64'(WINDOW - 1)) / 64'(WINDOW);
   localparam int VAR_SHIFT   = SQ_BITS + WIN_BITS;
   localparam int VAR_PROD_W  = 2 * SQ_BITS + 1;
   localparam longint unsigned VAR_RCP =
      ((64'd1 << VAR_SHIFT) + 64'(WINDOW - 1)) / 64'(WINDOW);

   wmv_ctrl_type              ctrl;
   logic                      out_free;

   logic [LVL_EXT_W-1:0]      level_ext;
   logic [LEVEL_BITS-1:0]     level_in;
   logic [LEVEL_BITS-1:0]     head;
   logic [TOTAL_BITS-1:0]     total;

   logic [MEAN_PROD_W-1:0]    mean_prod;
   logic [LEVEL_BITS-1:0]     mean_q;
   logic [VAR_PROD_W-1:0]     var_prod;
   logic [SQR_W-1:0]          var_q;
   logic [SQR_W-1:0]          var_ff;
   logic [CSU_W-1:0]          rem_ff;
   logic [CSU_W-1:0]          rem_in;
   logic [LEVEL_BITS-1:0]     mean_ff;
   logic [LEVEL_BITS-1:0]     delta;
   logic [SQR_W-1:0]          sq_ff;
   logic [SQR_W-1:0]          sq_in;
   logic [SQ_BITS-1:0]        acc_ff;
   logic [SQ_BITS-1:0]        acc_in;
   logic [SPREAD_W-1:0]       spread_ff;
   logic [SPREAD_W-1:0]       spread_sat;
   logic [VAR_EXT_W-1:0]      var_ext;
   logic [SPREAD_W-1:0]       rad_ff;
   logic [ROOT_BITS-1:0]      root_ff;
   logic [MEAN_EXT_W-1:0]     mean_ext;
   logic [MEAN_W-1:0]         mean_sat;

   logic [CSU_W-1:0]          opa;
   logic [CSU_W-1:0]          opb;
   logic [CSU_W-1:0]          diff;
   logic                      ge;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [MEAN_W-1:0]         rsp_mean_ff;
   logic [SPREAD_W-1:0]       rsp_spread_ff;
   logic [DEV_W-1:0]          rsp_dev_ff;

   logic [19:0]               dev_sq;
   logic [19:0]               dev_up_sq;

   assign out_free = ~rsp_valid_ff | rsp_ready;

   wmv_ctrl #(
      .WINDOW (WINDOW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .req_ready (req_ready),
      .ctrl      (ctrl)
   );

   // only the low LEVEL_BITS of the level are kept
   assign level_ext = LVL_EXT_W'(req_level);
   assign level_in  = level_ext[LEVEL_BITS-1:0];

   wmv_window #(
      .WINDOW     (WINDOW),
      .LEVEL_BITS (LEVEL_BITS)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (ctrl.accept),
      .rotate_en (ctrl.sq_mul),
      .level_in  (level_in),
      .head      (head),
      .total     (total)
   );

   // root digit trial: remainder with next two radicand bits against 4*root+1
   assign opa = {rem_ff[CSU_W-3:0], rad_ff[SPREAD_W-1 -: 2]};
   assign opb = CSU_W'({root_ff, 2'b01});

   wmv_csu u_csu (
      .opa  (opa),
      .opb  (opb),
      .diff (diff),
      .ge   (ge)
   );

   assign mean_prod = MEAN_PROD_W'(total) * MEAN_PROD_W'(MEAN_RCP);
   assign mean_q    = mean_prod[MEAN_SHIFT +: LEVEL_BITS];
   assign var_prod  = VAR_PROD_W'(acc_ff) * VAR_PROD_W'(VAR_RCP);
   assign var_q     = var_prod[VAR_SHIFT +: SQR_W];

   assign delta  = (head >= mean_ff) ? (head - mean_ff) : (mean_ff - head);
   assign sq_in  = SQR_W'(delta) * SQR_W'(delta);
   assign acc_in = acc_ff + SQ_BITS'(sq_ff);

   always_comb begin
      rem_in = rem_ff;
      if (ctrl.root_load) begin
         rem_in = '0;
      end else if (ctrl.root_step) begin
         rem_in = ge ? diff : opa;
      end
   end

   assign var_ext    = VAR_EXT_W'(var_ff);
   assign spread_sat = (var_ext > VAR_EXT_W'(SPREAD_MAX)) ? SPREAD_W'(SPREAD_MAX)
                                                          : var_ext[SPREAD_W-1:0];
   assign mean_ext   = MEAN_EXT_W'(mean_ff);
   assign mean_sat   = (mean_ext > MEAN_EXT_W'(MEAN_MAX)) ? MEAN_W'(MEAN_MAX)
                                                          : mean_ext[MEAN_W-1:0];

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      if (ctrl.mean_calc) begin
         mean_ff <= mean_q;
         acc_ff  <= '0;
      end else if (ctrl.sq_acc) begin
         acc_ff <= acc_in;
      end
      if (ctrl.sq_mul) begin
         sq_ff <= sq_in;
      end
      if (ctrl.var_calc) begin
         var_ff <= var_q;
      end
      if (ctrl.root_load) begin
         spread_ff <= spread_sat;
         rad_ff    <= spread_sat;
         root_ff   <= '0;
      end else if (ctrl.root_step) begin
         rad_ff  <= {rad_ff[SPREAD_W-3:0], 2'b00};
         root_ff <= {root_ff[ROOT_BITS-2:0], ge};
      end
   end

   // result register
   assign rsp_valid_in = ctrl.finish | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         rsp_mean_ff   <= mean_sat;
         rsp_spread_ff <= spread_ff;
         rsp_dev_ff    <= DEV_W'(root_ff);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_mean      = rsp_mean_ff;
   assign rsp_spread    = rsp_spread_ff;
   assign rsp_deviation = rsp_dev_ff;

   assign dev_sq    = 20'(rsp_deviation) * 20'(rsp_deviation);
   assign dev_up_sq = (20'(rsp_deviation) + 20'd1) * (20'(rsp_deviation) + 20'd1);

   `WMV_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "busy")
   `WMV_ASSERT_SAME(a_rsp_from_finish, clock, reset, $rose(rsp_valid), $past(ctrl.finish), "load")
   `WMV_ASSERT_SAME(a_root_floor, clock, reset, rsp_valid, (dev_sq <= 20'(rsp_spread)) && (dev_up_sq > 20'(rsp_spread)), "root")

endmodule

`default_nettype wire

@@ rtl/wmv_csu.sv @@
// ----------------------------------------------------------------------------
// wmv_csu
// Single compare-subtract unit used by every root digit step.
// ----------------------------------------------------------------------------
`default_nettype none

module wmv_csu (
   input  wire logic [wmv_pkg::CSU_W-1:0] opa,
   input  wire logic [wmv_pkg::CSU_W-1:0] opb,
   output logic      [wmv_pkg::CSU_W-1:0] diff,
   output logic                           ge
);
   import wmv_pkg::*;

   logic [CSU_W:0] full;

   assign full = {1'b0, opa} - {1'b0, opb};
   assign diff = full[CSU_W-1:0];
   assign ge   = ~full[CSU_W];

endmodule

`default_nettype wire

@@ rtl/wmv_window.sv @@
// ----------------------------------------------------------------------------
// wmv_window
// Window store as a shift line with running total and held level.
// ----------------------------------------------------------------------------
`default_nettype none

module wmv_window #(
   parameter int WINDOW     = wmv_pkg::WINDOW_DEF,
   parameter int LEVEL_BITS = wmv_pkg::LEVEL_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  shift_en,
   input  wire logic                                  rotate_en,
   input  wire logic [LEVEL_BITS-1:0]                 level_in,
   output logic      [LEVEL_BITS-1:0]                 head,
   output logic      [LEVEL_BITS+$clog2(WINDOW)-1:0]  total
);
   import wmv_pkg::*;

   localparam int TOTAL_BITS = LEVEL_BITS + $clog2(WINDOW);

   logic [LEVEL_BITS-1:0] ring_ff [WINDOW];
   logic [LEVEL_BITS-1:0] ring_in;
   logic [LEVEL_BITS-1:0] held_ff;
   logic [TOTAL_BITS-1:0] total_ff;
   logic [TOTAL_BITS-1:0] total_in;

   // oldest entry sits at the far end of the line
   assign head     = ring_ff[WINDOW-1];
   assign total    = total_ff;
   assign ring_in  = shift_en ? held_ff : ring_ff[WINDOW-1];
   assign total_in = total_ff - TOTAL_BITS'(ring_ff[WINDOW-1]) + TOTAL_BITS'(held_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            ring_ff[i] <= '0;
         end
         held_ff  <= '0;
         total_ff <= '0;
      end else begin
         if (shift_en || rotate_en) begin
            ring_ff[0] <= ring_in;
            for (int i = 1; i < WINDOW; i++) begin
               ring_ff[i] <= ring_ff[i-1];
            end
         end
         if (shift_en) begin
            held_ff  <= level_in;
            total_ff <= total_in;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/wmv_ctrl.sv @@
// ----------------------------------------------------------------------------
// wmv_ctrl
// Sequencer: steps through mean, squares, variance and the root digits.
// ----------------------------------------------------------------------------
`default_nettype none

module wmv_ctrl #(
   parameter int WINDOW = wmv_pkg::WINDOW_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  out_free,
   output logic                       req_ready,
   output wmv_pkg::wmv_ctrl_type      ctrl
);
   import wmv_pkg::*;

   localparam int CNT_W = $clog2(WINDOW + ROOT_BITS + 1);

   wmv_state_type     state_ff;
   wmv_state_type     state_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic              last_sq;
   logic              last_root;

   assign last_sq   = (cnt_ff == CNT_W'(WINDOW));
   assign last_root = (cnt_ff == CNT_W'(ROOT_BITS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_MEAN;
         ST_MEAN:      state_in = ST_SQUARE;
         ST_SQUARE:    if (last_sq) state_in = ST_VAR;
         ST_VAR:       state_in = ST_ROOT_LOAD;
         ST_ROOT_LOAD: state_in = ST_ROOT;
         ST_ROOT:      if (last_root) state_in = ST_FINISH;
         ST_FINISH:    if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // step counter restarts whenever a phase ends
   always_comb begin
      cnt_in = '0;
      case (state_ff)
         ST_SQUARE:   if (!last_sq)   cnt_in = cnt_ff + 1'b1;
         ST_ROOT:     if (!last_root) cnt_in = cnt_ff + 1'b1;
         default:     cnt_in = '0;
      endcase
   end

   always_comb begin
      ctrl      = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = ~reset;
            ctrl.accept = req_valid & ~reset;
         end
         ST_MEAN:      ctrl.mean_calc = 1'b1;
         ST_SQUARE: begin
            ctrl.sq_mul = (cnt_ff < CNT_W'(WINDOW));
            ctrl.sq_acc = (cnt_ff != '0);
         end
         ST_VAR:       ctrl.var_calc  = 1'b1;
         ST_ROOT_LOAD: ctrl.root_load = 1'b1;
         ST_ROOT:      ctrl.root_step = 1'b1;
         ST_FINISH:    ctrl.finish    = out_free;
         default:      ctrl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire
